// ===== sv/dnsu_pkg.sv =====
`default_nettype none
package dnsu_pkg;

    localparam int NAME_FIELD_BYTES_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT      = 4;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_CASE_BIT  = 8'h20;

    // superscript digits in utf-8: lead byte and the three trail bytes
    localparam logic [7:0] SUP_LEAD  = 8'hC2;
    localparam logic [7:0] SUP_ONE   = 8'hB9;
    localparam logic [7:0] SUP_TWO   = 8'hB2;
    localparam logic [7:0] SUP_THREE = 8'hB3;

    // upper half of code page 437 as unicode code points
    localparam logic [15:0] CP437_HIGH [0:127] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // one queued command: up to three utf-8 bytes, then status if last
    typedef struct packed {
        logic [2:0][7:0] enc;
        logic [1:0]      len;
        logic            sep;
        logic            last;
        logic            invalid;
    } dnsu_cmd_t;

endpackage
`default_nettype wire

// ===== sv/dnsu_front.sv =====
`default_nettype none
module dnsu_front #(
    parameter int NAME_FIELD_BYTES = dnsu_pkg::NAME_FIELD_BYTES_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          field_byte,
    input  wire logic                field_end,
    output logic                     push,
    output dnsu_pkg::dnsu_cmd_t      cmd
);

    localparam int CW = $clog2(NAME_FIELD_BYTES + 1);

    logic          terminated_reg, terminated_next;
    logic          at_first_reg, at_first_next;
    logic          invalid_reg, invalid_next;
    logic [CW-1:0] taken_reg, taken_next;

    logic          active;
    logic          is_ctrl;
    logic          is_sep;
    logic          has_bytes;
    logic [15:0]   code;
    logic [2:0][7:0] enc;
    logic [1:0]    len;

    always_comb
    begin
        active  = !terminated_reg && (taken_reg < CW'(NAME_FIELD_BYTES));
        is_ctrl = (field_byte < dnsu_pkg::CH_SPACE) || (field_byte == dnsu_pkg::CH_DEL);
        is_sep  = (field_byte == dnsu_pkg::CH_BACKSLASH) || (field_byte == dnsu_pkg::CH_SLASH);
        code    = field_byte[7] ? dnsu_pkg::CP437_HIGH[field_byte[6:0]] : {8'h00, field_byte};

        enc = '0;
        priority if (is_sep)
        begin
            enc[0] = dnsu_pkg::CH_SLASH;
            len    = 2'd1;
        end
        else if (code < 16'h0080)
        begin
            enc[0] = code[7:0];
            len    = 2'd1;
        end
        else if (code < 16'h0800)
        begin
            enc[0] = {3'b110, code[10:6]};
            enc[1] = {2'b10, code[5:0]};
            len    = 2'd2;
        end
        else
        begin
            enc[0] = {4'b1110, code[15:12]};
            enc[1] = {2'b10, code[11:6]};
            enc[2] = {2'b10, code[5:0]};
            len    = 2'd3;
        end

        has_bytes = active && (field_byte != dnsu_pkg::CH_NUL);

        terminated_next = terminated_reg;
        at_first_next   = at_first_reg;
        invalid_next    = invalid_reg;
        taken_next      = taken_reg;
        if (accept && active)
        begin
            taken_next = taken_reg + CW'(1);
            if (field_byte == dnsu_pkg::CH_NUL)
            begin
                if (at_first_reg)
                begin
                    invalid_next = 1'b1;
                end
                terminated_next = 1'b1;
            end
            else if (is_ctrl)
            begin
                invalid_next = 1'b1;
            end
            at_first_next = 1'b0;
        end

        push        = accept && (has_bytes || field_end);
        cmd.enc     = enc;
        cmd.len     = has_bytes ? len : 2'd0;
        cmd.sep     = is_sep;
        cmd.last    = field_end;
        cmd.invalid = invalid_next;

        // field end returns the name state to its start
        if (accept && field_end)
        begin
            terminated_next = 1'b0;
            at_first_next   = 1'b1;
            invalid_next    = 1'b0;
            taken_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminated_reg <= 1'b0;
            at_first_reg   <= 1'b1;
            invalid_reg    <= 1'b0;
            taken_reg      <= '0;
        end
        else
        begin
            terminated_reg <= terminated_next;
            at_first_reg   <= at_first_next;
            invalid_reg    <= invalid_next;
            taken_reg      <= taken_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dnsu_queue.sv =====
`default_nettype none
module dnsu_queue #(
    parameter int DEPTH = dnsu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dnsu_pkg::dnsu_cmd_t cmd_in,
    input  wire logic                pop,
    output dnsu_pkg::dnsu_cmd_t      cmd_out,
    output logic                     not_empty,
    output logic                     full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    dnsu_pkg::dnsu_cmd_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb
    begin
        not_empty = (count_reg != '0);
        full      = (count_reg == NW'(DEPTH));
        do_push   = push && !full;
        do_pop    = pop && not_empty;
        cmd_out   = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dnsu_back.sv =====
`default_nettype none
module dnsu_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire dnsu_pkg::dnsu_cmd_t cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               out_byte,
    output logic                     is_status,
    output logic                     name_invalid,
    output logic                     unsafe_name
);

    logic [1:0] part_reg, part_next;
    logic       unsafe_reg, unsafe_next;
    logic [5:0] comp_len_reg, comp_len_next;
    logic       dot_reg, dot_next;
    logic [5:0] stem_len_reg, stem_len_next;
    logic       meaningful_reg, meaningful_next;
    logic       bad_reg, bad_next;
    logic [7:0] last_byte_reg, last_byte_next;
    logic [7:0] head_reg [8];

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       is_status_reg, is_status_next;
    logic       invalid_out_reg, invalid_out_next;
    logic       unsafe_out_reg, unsafe_out_next;

    logic       load;
    logic       at_status;
    logic       feed;
    logic       clear;
    logic [7:0] c;
    logic [7:0] u [7];
    logic       res3, res6, res7, com_lpt, dev_digit, dev_sup;
    logic       safe;

    function automatic logic [7:0] upper_ascii(input logic [7:0] ch);
        logic [7:0] r;
        r = ch;
        if (ch >= dnsu_pkg::CH_LOWER_A && ch <= dnsu_pkg::CH_LOWER_Z)
        begin
            r = ch - dnsu_pkg::CH_CASE_BIT;
        end
        return r;
    endfunction

    // checks the component held in the registers
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            u[i] = upper_ascii(head_reg[i]);
        end
        res3 = (stem_len_reg == 6'd3) &&
               (({u[0], u[1], u[2]} == "CON") || ({u[0], u[1], u[2]} == "PRN") ||
                ({u[0], u[1], u[2]} == "AUX") || ({u[0], u[1], u[2]} == "NUL"));
        res6 = (stem_len_reg == 6'd6) &&
               (({u[0], u[1], u[2], u[3], u[4], u[5]} == "CONIN$") ||
                ({u[0], u[1], u[2], u[3], u[4], u[5]} == "CLOCK$"));
        res7 = (stem_len_reg == 6'd7) &&
               ({u[0], u[1], u[2], u[3], u[4], u[5], u[6]} == "CONOUT$");
        com_lpt = ({u[0], u[1], u[2]} == "COM") || ({u[0], u[1], u[2]} == "LPT");
        dev_digit = (stem_len_reg == 6'd4) && com_lpt &&
                    (head_reg[3] >= dnsu_pkg::CH_ZERO) && (head_reg[3] <= dnsu_pkg::CH_NINE);
        dev_sup = (stem_len_reg == 6'd5) && com_lpt && (head_reg[3] == dnsu_pkg::SUP_LEAD) &&
                  ((head_reg[4] == dnsu_pkg::SUP_ONE) || (head_reg[4] == dnsu_pkg::SUP_TWO) ||
                   (head_reg[4] == dnsu_pkg::SUP_THREE));
        safe = (comp_len_reg != 6'd0) && !bad_reg && meaningful_reg &&
               (last_byte_reg != dnsu_pkg::CH_DOT) && (last_byte_reg != dnsu_pkg::CH_SPACE) &&
               !res3 && !res6 && !res7 && !dev_digit && !dev_sup;
    end

    always_comb
    begin
        load      = cmd_valid && (!out_valid_reg || !out_stall);
        at_status = (part_reg == cmd.len);
        c         = cmd.enc[part_reg];
        feed      = load && !at_status && !cmd.sep;
        clear     = load && (at_status || cmd.sep);
        pop       = 1'b0;
        part_next = part_reg;
        unsafe_next = unsafe_reg;

        out_valid_next   = out_valid_reg && out_stall;
        out_byte_next    = out_byte_reg;
        is_status_next   = is_status_reg;
        invalid_out_next = invalid_out_reg;
        unsafe_out_next  = unsafe_out_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            if (at_status)
            begin
                out_byte_next    = 8'h00;
                is_status_next   = 1'b1;
                invalid_out_next = cmd.invalid;
                unsafe_out_next  = unsafe_reg || !safe;
                unsafe_next      = 1'b0;
                pop              = 1'b1;
                part_next        = 2'd0;
            end
            else
            begin
                out_byte_next    = c;
                is_status_next   = 1'b0;
                invalid_out_next = 1'b0;
                unsafe_out_next  = 1'b0;
                if (cmd.sep)
                begin
                    unsafe_next = unsafe_reg || !safe;
                end
                if (part_reg == cmd.len - 2'd1 && !cmd.last)
                begin
                    pop       = 1'b1;
                    part_next = 2'd0;
                end
                else
                begin
                    part_next = part_reg + 2'd1;
                end
            end
        end

        comp_len_next   = comp_len_reg;
        dot_next        = dot_reg;
        stem_len_next   = stem_len_reg;
        meaningful_next = meaningful_reg;
        bad_next        = bad_reg;
        last_byte_next  = last_byte_reg;
        if (clear)
        begin
            comp_len_next   = 6'd0;
            dot_next        = 1'b0;
            stem_len_next   = 6'd0;
            meaningful_next = 1'b0;
            bad_next        = 1'b0;
            last_byte_next  = 8'h00;
        end
        else if (feed)
        begin
            if (c < dnsu_pkg::CH_SPACE || c == dnsu_pkg::CH_DEL ||
                c == dnsu_pkg::CH_COLON || c == dnsu_pkg::CH_LESS ||
                c == dnsu_pkg::CH_GREATER || c == dnsu_pkg::CH_QUOTE ||
                c == dnsu_pkg::CH_PIPE || c == dnsu_pkg::CH_QUESTION ||
                c == dnsu_pkg::CH_STAR)
            begin
                bad_next = 1'b1;
            end
            if (c != dnsu_pkg::CH_DOT && c != dnsu_pkg::CH_SPACE)
            begin
                meaningful_next = 1'b1;
            end
            if (!dot_reg)
            begin
                if (c == dnsu_pkg::CH_DOT)
                begin
                    dot_next = 1'b1;
                end
                else if (c != dnsu_pkg::CH_SPACE)
                begin
                    stem_len_next = (comp_len_reg < 6'd63) ? comp_len_reg + 6'd1 : 6'd63;
                end
            end
            last_byte_next = c;
            if (comp_len_reg < 6'd63)
            begin
                comp_len_next = comp_len_reg + 6'd1;
            end
        end

        out_valid    = out_valid_reg;
        out_byte     = out_byte_reg;
        is_status    = is_status_reg;
        name_invalid = invalid_out_reg;
        unsafe_name  = unsafe_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg       <= 2'd0;
            unsafe_reg     <= 1'b0;
            comp_len_reg   <= 6'd0;
            dot_reg        <= 1'b0;
            stem_len_reg   <= 6'd0;
            meaningful_reg <= 1'b0;
            bad_reg        <= 1'b0;
            last_byte_reg  <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            part_reg       <= part_next;
            unsafe_reg     <= unsafe_next;
            comp_len_reg   <= comp_len_next;
            dot_reg        <= dot_next;
            stem_len_reg   <= stem_len_next;
            meaningful_reg <= meaningful_next;
            bad_reg        <= bad_next;
            last_byte_reg  <= last_byte_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers and the component head carry no reset
    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        is_status_reg   <= is_status_next;
        invalid_out_reg <= invalid_out_next;
        unsafe_out_reg  <= unsafe_out_next;
        if (feed && comp_len_reg < 6'd8)
        begin
            head_reg[comp_len_reg[2:0]] <= c;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dos_name_to_safe_utf8.sv =====
`default_nettype none
// dos name field to utf-8 converter
// input channel: in_valid / in_stall carry one raw code page 437 byte per word
// (field_byte) and field_end on the last byte of the name field
// output channel: out_valid / out_stall carry one result word: a utf-8 byte of
// the name (is_status low) or, after the last byte, a status word with
// name_invalid and unsafe_name (is_status high, out_byte zero)
// a word is taken at a rising edge with valid high and stall low
// the front takes one input word per cycle while its four-entry command queue
// has room; the back emits one result word per cycle while out_stall is low,
// so an input byte gives at most three result words and a field end one more
// for the status word; sustained rate is set by the back's output register
// a word's first result passes the queue and the output register to out_valid
// bytes after a nul or past NAME_FIELD_BYTES give only a field end's status
// while out_stall is high the output word holds and the queue fills, then
// in_stall rises; reset empties the queue and starts a fresh name
module dos_name_to_safe_utf8 #(
    parameter int NAME_FIELD_BYTES = dnsu_pkg::NAME_FIELD_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH      = dnsu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] field_byte,
    input  wire logic       field_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            is_status,
    output logic            name_invalid,
    output logic            unsafe_name
);

    logic                 q_push;
    logic                 q_full;
    dnsu_pkg::dnsu_cmd_t  front_cmd;
    dnsu_pkg::dnsu_cmd_t  back_cmd;
    logic                 accept;
    logic                 q_not_empty;
    logic                 pop;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    dnsu_front #(
        .NAME_FIELD_BYTES(NAME_FIELD_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .field_byte (field_byte),
        .field_end  (field_end),
        .push       (q_push),
        .cmd        (front_cmd)
    );

    dnsu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .cmd_in    (front_cmd),
        .pop       (pop),
        .cmd_out   (back_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    dnsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_not_empty),
        .cmd          (back_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_status    (is_status),
        .name_invalid (name_invalid),
        .unsafe_name  (unsafe_name)
    );

    // a status word never carries a name byte
    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> out_byte == 8'h00)
        else $error("status word with nonzero byte");

    // name bytes never carry status flags
    a_byte_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> !name_invalid && !unsafe_name)
        else $error("name byte with status flags");

    // an input word that ends the field always reaches the queue
    a_end_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && field_end |-> q_push)
        else $error("field end lost");

    // a new word enters the output only from a queued command
    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(q_not_empty))
        else $error("output word without command");

endmodule
`default_nettype wire

// ===== tb/dos_name_to_safe_utf8_tb.sv =====
`timescale 1ns / 100ps

module dos_name_to_safe_utf8_tb;

    localparam int FIELD_BYTES   = dnsu_pkg::NAME_FIELD_BYTES_DEFAULT;
    localparam int RANDOM_BYTES  = 230;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 60;
    localparam int DIRECTED_ROWS = 23;

    localparam logic [7:0] SLASH     = 8'h2F;
    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] DQUOTE    = 8'h22;
    localparam logic [7:0] SUPER_TWO = 8'hFD;

    // upper half of code page 437, unicode code points
    localparam logic [15:0] CP437_UPPER [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       name_invalid;
        logic       unsafe_name;
    } name_word_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       typed;
        logic       want_invalid;
        logic       want_unsafe;
    } field_row_t;

    localparam field_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1},   // empty name
        '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},   // top byte, no-break space
        '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},   // first byte of the upper half
        '{8'h63, 1'b0, 1'b0, 1'b0, 1'b0},   // c
        '{8'h4F, 1'b0, 1'b0, 1'b0, 1'b0},   // O
        '{8'h6E, 1'b1, 1'b1, 1'b0, 1'b1},   // n: console device, mixed case
        '{8'h4C, 1'b0, 1'b0, 1'b0, 1'b0},   // L
        '{8'h50, 1'b0, 1'b0, 1'b0, 1'b0},   // P
        '{8'h54, 1'b0, 1'b0, 1'b0, 1'b0},   // T
        '{8'hFD, 1'b1, 1'b1, 1'b0, 1'b1},   // printer port with superscript two
        '{8'h41, 1'b0, 1'b0, 1'b0, 1'b0},   // A
        '{8'h2F, 1'b1, 1'b1, 1'b0, 1'b1},   // trailing separator
        '{8'h01, 1'b1, 1'b1, 1'b1, 1'b1},   // control byte
        '{8'h7F, 1'b1, 1'b1, 1'b1, 1'b1},   // delete
        '{8'h3F, 1'b1, 1'b1, 1'b0, 1'b1},   // reserved punctuation
        '{8'h2E, 1'b1, 1'b1, 1'b0, 1'b1},   // dots only
        '{8'hB0, 1'b1, 1'b1, 1'b0, 1'b0},   // three-byte encoding
        '{8'h58, 1'b0, 1'b0, 1'b0, 1'b0},   // X
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},   // nul ends the name
        '{8'h59, 1'b1, 1'b1, 1'b0, 1'b0},   // ignored byte on the field end
        '{8'h5C, 1'b1, 1'b1, 1'b0, 1'b1},   // backslash alone
        '{8'h61, 1'b0, 1'b0, 1'b0, 1'b0},   // a
        '{8'h20, 1'b1, 1'b1, 1'b0, 1'b1}    // trailing space
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] field_byte;
    logic       field_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       is_status;
    logic       name_invalid;
    logic       unsafe_name;

    // converter state as predicted
    logic       name_done;
    logic       name_first;
    logic       seen_invalid;
    logic       seen_unsafe;
    int         field_count;
    logic [5:0] part_len;
    logic [5:0] part_stem;
    logic [7:0] part_head [8];
    logic       part_dot;
    logic       part_meaningful;
    logic       part_illegal;
    logic [7:0] part_last;

    name_word_t expected_words [$];
    logic [7:0] name_bytes [$];
    string      device_stems [9] = '{"CON", "PRN", "AUX", "NUL", "CONIN$", "CONOUT$",
                                     "CLOCK$", "COM", "LPT"};
    string      reserved_punct = ":<>|?*";

    logic       status_typed;
    logic       typed_invalid;
    logic       typed_unsafe;
    logic       tx_quiet;
    logic       rx_quiet;
    logic       long_hold_due;
    int         taken_count;
    int         error_count;
    int         cycle_count;

    dos_name_to_safe_utf8 #(
        .NAME_FIELD_BYTES(FIELD_BYTES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .field_byte  (field_byte),
        .field_end   (field_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_status   (is_status),
        .name_invalid(name_invalid),
        .unsafe_name (unsafe_name)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    function automatic void clear_part();
        part_len        = '0;
        part_stem       = '0;
        part_dot        = 1'b0;
        part_meaningful = 1'b0;
        part_illegal    = 1'b0;
        part_last       = '0;
        for (int i = 0; i < 8; i++)
            part_head[i] = '0;
    endfunction

    function automatic void reset_name();
        name_done    = 1'b0;
        name_first   = 1'b1;
        seen_invalid = 1'b0;
        seen_unsafe  = 1'b0;
        field_count  = 0;
        clear_part();
    endfunction

    function automatic void feed_part(input logic [7:0] c);
        if (c < 8'h20 || c == 8'h7F || c == ":" || c == "<" || c == ">" || c == DQUOTE ||
            c == "|" || c == "?" || c == "*")
            part_illegal = 1'b1;
        if (c != "." && c != " ")
            part_meaningful = 1'b1;
        if (!part_dot)
        begin
            if (c == ".")
                part_dot = 1'b1;
            else if (c != " ")
                part_stem = (part_len < 6'd63) ? part_len + 6'd1 : 6'd63;
        end
        if (part_len < 6'd8)
            part_head[part_len[2:0]] = c;
        part_last = c;
        if (part_len < 6'd63)
            part_len = part_len + 6'd1;
    endfunction

    function automatic logic stem_is(input string w);
        if (part_stem != w.len())
            return 1'b0;
        for (int i = 0; i < w.len(); i++)
            if (upcase(part_head[i]) != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic part_is_safe();
        logic com_or_lpt;
        if (part_len == 0 || part_illegal || !part_meaningful)
            return 1'b0;
        if (part_last == "." || part_last == " ")
            return 1'b0;
        for (int w = 0; w < 7; w++)
            if (stem_is(device_stems[w]))
                return 1'b0;
        com_or_lpt = (upcase(part_head[0]) == "C" && upcase(part_head[1]) == "O" &&
                      upcase(part_head[2]) == "M") ||
                     (upcase(part_head[0]) == "L" && upcase(part_head[1]) == "P" &&
                      upcase(part_head[2]) == "T");
        if (com_or_lpt && part_stem == 6'd4 && part_head[3] >= "0" && part_head[3] <= "9")
            return 1'b0;
        // superscript digit is two utf-8 bytes, so the stem is five long
        if (com_or_lpt && part_stem == 6'd5 && part_head[3] == 8'hC2 &&
            (part_head[4] == 8'hB9 || part_head[4] == 8'hB2 || part_head[4] == 8'hB3))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_part();
        if (!part_is_safe())
            seen_unsafe = 1'b1;
        clear_part();
    endfunction

    function automatic void expect_word(input logic [7:0] b, input logic status,
                                        input logic inv, input logic uns);
        name_word_t w;
        w.out_byte     = b;
        w.is_status    = status;
        w.name_invalid = inv;
        w.unsafe_name  = uns;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_field_word(input logic [7:0] b, input logic last);
        logic [15:0] cp;
        logic [7:0]  enc [3];
        int          n;
        if (!name_done && field_count < FIELD_BYTES)
        begin
            field_count++;
            if (b == 8'h00)
            begin
                if (name_first)
                    seen_invalid = 1'b1;
                name_done = 1'b1;
            end
            else
            begin
                if (b < 8'h20 || b == 8'h7F)
                    seen_invalid = 1'b1;
                if (b == BACKSLASH || b == SLASH)
                begin
                    close_part();
                    expect_word(SLASH, 1'b0, 1'b0, 1'b0);
                end
                else
                begin
                    cp = b[7] ? CP437_UPPER[b[6:0]] : {8'h00, b};
                    if (cp < 16'h0080)
                    begin
                        enc[0] = cp[7:0];
                        n = 1;
                    end
                    else if (cp < 16'h0800)
                    begin
                        enc[0] = 8'hC0 | {3'b000, cp[10:6]};
                        enc[1] = 8'h80 | {2'b00, cp[5:0]};
                        n = 2;
                    end
                    else
                    begin
                        enc[0] = 8'hE0 | {4'h0, cp[15:12]};
                        enc[1] = 8'h80 | {2'b00, cp[11:6]};
                        enc[2] = 8'h80 | {2'b00, cp[5:0]};
                        n = 3;
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        feed_part(enc[i]);
                        expect_word(enc[i], 1'b0, 1'b0, 1'b0);
                    end
                end
            end
            name_first = 1'b0;
        end
        if (last)
        begin
            close_part();
            if (status_typed)
                expect_word(8'h00, 1'b1, typed_invalid, typed_unsafe);
            else
                expect_word(8'h00, 1'b1, seen_invalid, seen_unsafe);
            reset_name();
        end
    endfunction

    function automatic int idle_length(input logic quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] random_char();
        int         roll;
        logic [7:0] c;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            c = 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        else if (roll < 60)
            c = 8'h30 + 8'($urandom_range(0, 9));
        else if (roll < 80)
            c = 8'($urandom_range(8'h80, 8'hFF));
        else if (roll < 87)
            c = $urandom_range(0, 1) ? "." : " ";
        else if (roll < 94)
            c = ($urandom_range(0, 6) == 0) ? DQUOTE :
                reserved_punct[$urandom_range(0, reserved_punct.len() - 1)];
        else
        begin
            c = 8'($urandom_range(1, 8'h20));
            if (c == 8'h20)
                c = 8'h7F;
        end
        return c;
    endfunction

    task automatic push_text(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 2) == 0)
                c = c | 8'h20;
            name_bytes.push_back(c);
        end
    endtask

    task automatic add_component();
        int pick;
        int stem;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            stem = $urandom_range(0, 8);
            push_text(device_stems[stem]);
            // serial and printer ports need a digit
            if (stem >= 7)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    name_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
                    2:       name_bytes.push_back(SUPER_TWO);
                    default: name_bytes.push_back(random_char());
                endcase
            end
            case ($urandom_range(0, 5))
                0:
                begin
                    name_bytes.push_back(".");
                    repeat ($urandom_range(1, 3)) name_bytes.push_back(random_char());
                end
                1:
                begin
                    repeat ($urandom_range(1, 2)) name_bytes.push_back(" ");
                    if ($urandom_range(0, 1))
                    begin
                        name_bytes.push_back(".");
                        name_bytes.push_back(random_char());
                    end
                end
                2:       name_bytes.push_back(".");
                3:       name_bytes.push_back(random_char());
                default: ;
            endcase
        end
        else if (pick < 8)
            repeat ($urandom_range(1, 8)) name_bytes.push_back(random_char());
        else
            repeat ($urandom_range(1, 3)) name_bytes.push_back($urandom_range(0, 1) ? "." : " ");
    endtask

    task automatic build_name();
        int kind;
        name_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9)
            repeat ($urandom_range(1, 20)) name_bytes.push_back(8'($urandom_range(0, 255)));
        else if (kind == 8)
        begin
            name_bytes.push_back(8'h00);
            repeat ($urandom_range(0, FIELD_BYTES - 1))
                name_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                if (name_bytes.size() != 0)
                    name_bytes.push_back($urandom_range(0, 1) ? SLASH : BACKSLASH);
                add_component();
            end
            if ($urandom_range(0, 7) == 0)
                name_bytes.push_back($urandom_range(0, 1) ? SLASH : BACKSLASH);
            if ($urandom_range(0, 7) == 0)
                name_bytes.push_front($urandom_range(0, 1) ? SLASH : BACKSLASH);
            // fixed-size field: nul then leftover garbage up to the field size
            if (name_bytes.size() < FIELD_BYTES && $urandom_range(0, 1))
            begin
                name_bytes.push_back(8'h00);
                while (name_bytes.size() < FIELD_BYTES)
                    name_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) name_bytes.push_back(random_char());
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_length(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        field_byte <= b;
        field_end  <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        taken_count++;
        predict_field_word(b, last);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %02h, got %02h", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        name_word_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_words.size() == 0)
            begin
                $error("word with nothing expected: out_byte %02h is_status %b",
                       out_byte, is_status);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("out_byte", want.out_byte, out_byte);
                compare_field("is_status", want.is_status, is_status);
                compare_field("name_invalid", want.name_invalid, name_invalid);
                compare_field("unsafe_name", want.unsafe_name, unsafe_name);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on each request
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = idle_length(rx_quiet);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    initial
    begin
        int quiet_names;
        int name_index;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        field_byte    = 8'h00;
        field_end     = 1'b0;
        status_typed  = 1'b0;
        typed_invalid = 1'b0;
        typed_unsafe  = 1'b0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        long_hold_due = 1'b0;
        taken_count   = 0;
        error_count   = 0;
        cycle_count   = 0;
        quiet_names   = 0;
        name_index    = 0;
        reset_name();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            status_typed  = DIRECTED[r].typed;
            typed_invalid = DIRECTED[r].want_invalid;
            typed_unsafe  = DIRECTED[r].want_unsafe;
            send_word(DIRECTED[r].code, DIRECTED[r].last);
        end
        status_typed = 1'b0;
        drain_results();

        while (taken_count < RANDOM_BYTES)
        begin
            if (name_index == 12 || name_index == 45)
            begin
                // hold the output off while names keep coming
                long_hold_due = 1'b1;
                quiet_names   = 4;
            end
            if (name_index == 30 || name_index == 70)
                drain_results();
            if (quiet_names > 0)
                quiet_names--;
            else if ($urandom_range(0, 9) == 0)
                quiet_names = $urandom_range(2, 5);
            tx_quiet = (quiet_names > 0);
            rx_quiet = (quiet_names > 0);
            build_name();
            for (int i = 0; i < name_bytes.size(); i++)
                send_word(name_bytes[i], i == name_bytes.size() - 1);
            name_index++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
